[src/lmr_pkg.sv]
// ----------------------------------------------------------------------------
// lmr_pkg
// Shared types and constants for the LED mode render and PWM slot encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package lmr_pkg;

    localparam int BITS_PER_LED    = 24;
    localparam int SLOT_CNT_W      = $clog2(BITS_PER_LED + 1);
    localparam int PULSE_W         = 16;
    localparam int REPEAT_W        = 8;
    localparam int COLOUR_W        = 8;
    localparam int MODE_W          = 2;
    localparam int TICK_W          = 8;
    localparam int LED_POS_W       = 10;
    localparam int PLAYHEAD_W      = 5;
    localparam int CFG_INDEX_W     = 2;
    localparam int CFG_DATA_W      = 16;
    localparam int MAX_LEDS_DEFAULT = 64;

    localparam logic [PULSE_W-1:0]  ZERO_PULSE_RESET = PULSE_W'(90);
    localparam logic [PULSE_W-1:0]  ONE_PULSE_RESET  = PULSE_W'(210);
    localparam logic [REPEAT_W-1:0] IDLE_SLOT_RESET  = REPEAT_W'(80);

    localparam logic [MODE_W-1:0] MODE_OFF      = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ON       = 2'd1;
    localparam logic [MODE_W-1:0] MODE_BLINK    = 2'd2;
    localparam logic [MODE_W-1:0] MODE_PLAYHEAD = 2'd3;

    localparam logic [CFG_INDEX_W-1:0] REG_ZERO_PULSE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ONE_PULSE  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_IDLE_SLOTS = 2'd2;

    typedef struct packed {
        logic [PULSE_W-1:0]  zero_pulse_ticks;
        logic [PULSE_W-1:0]  one_pulse_ticks;
        logic [REPEAT_W-1:0] idle_slot_count;
    } lmr_cfg_t;

    typedef struct packed {
        logic [BITS_PER_LED-1:0] word;
        logic                    last;
    } lmr_word_t;

endpackage

`default_nettype wire

[src/lmr_cfg.sv]
// ----------------------------------------------------------------------------
// lmr_cfg
// Configuration register file: zero and one pulse compare values, idle gap.
// ----------------------------------------------------------------------------
`default_nettype none

module lmr_cfg
    import lmr_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    output lmr_cfg_t                    cfg
);

    lmr_cfg_t cfg_reg;
    lmr_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_ZERO_PULSE: cfg_next.zero_pulse_ticks = cfg_data[PULSE_W-1:0];
                REG_ONE_PULSE:  cfg_next.one_pulse_ticks  = cfg_data[PULSE_W-1:0];
                REG_IDLE_SLOTS: cfg_next.idle_slot_count  = cfg_data[REPEAT_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.zero_pulse_ticks <= ZERO_PULSE_RESET;
            cfg_reg.one_pulse_ticks  <= ONE_PULSE_RESET;
            cfg_reg.idle_slot_count  <= IDLE_SLOT_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

[src/lmr_render.sv]
// ----------------------------------------------------------------------------
// lmr_render
// Frame tick and LED position tracking, lit decision, colour word register.
// ----------------------------------------------------------------------------
`default_nettype none

module lmr_render
    import lmr_pkg::*;
#(
    parameter int MAX_LEDS = MAX_LEDS_DEFAULT
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [COLOUR_W-1:0] s_red,
    input  wire logic [COLOUR_W-1:0] s_green,
    input  wire logic [COLOUR_W-1:0] s_blue,
    input  wire logic [MODE_W-1:0]   s_led_mode,
    input  wire logic                s_last_led,
    output logic                     word_valid,
    output lmr_word_t                word,
    input  wire logic                word_take
);

    localparam int POS_W = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_LEDS - 1);

    logic [TICK_W-1:0] frame_tick_reg;
    logic [TICK_W-1:0] frame_tick_next;
    logic [POS_W-1:0]  led_position_reg;
    logic [POS_W-1:0]  led_position_next;
    logic              word_valid_reg;
    logic              word_valid_next;
    lmr_word_t         word_reg;
    lmr_word_t         word_next;
    logic              accept;
    logic              lit;
    logic [LED_POS_W-1:0] pos_ext;
    logic [LED_POS_W-1:0] head_ext;

    assign s_ready    = !word_valid_reg || word_take;
    assign accept     = s_valid && s_ready;
    assign word_valid = word_valid_reg;
    assign word       = word_reg;

    // tick advances on the first led of a frame and is used for that led
    assign frame_tick_next = (led_position_reg == '0) ? frame_tick_reg + 1'b1
                                                      : frame_tick_reg;
    assign pos_ext  = LED_POS_W'(led_position_reg);
    assign head_ext = LED_POS_W'(frame_tick_next[PLAYHEAD_W-1:0]);

    always_comb begin
        unique case (s_led_mode)
            MODE_ON:       lit = 1'b1;
            MODE_BLINK:    lit = frame_tick_next[TICK_W-1];
            MODE_PLAYHEAD: lit = (head_ext == pos_ext);
            default:       lit = 1'b0;
        endcase
    end

    always_comb begin
        word_next.word = lit ? {s_green, s_red, s_blue} : '0;
        word_next.last = s_last_led;
        if (s_last_led) begin
            led_position_next = '0;
        end else if (led_position_reg < POS_MAX) begin
            led_position_next = led_position_reg + 1'b1;
        end else begin
            led_position_next = led_position_reg;
        end
        if (accept) begin
            word_valid_next = 1'b1;
        end else if (word_take) begin
            word_valid_next = 1'b0;
        end else begin
            word_valid_next = word_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_tick_reg   <= '0;
            led_position_reg <= '0;
            word_valid_reg   <= 1'b0;
        end else begin
            word_valid_reg <= word_valid_next;
            if (accept) begin
                frame_tick_reg   <= frame_tick_next;
                led_position_reg <= led_position_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            word_reg <= word_next;
        end
    end

endmodule

`default_nettype wire

[src/lmr_serial.sv]
// ----------------------------------------------------------------------------
// lmr_serial
// Shifts the colour word out MSB first as PWM compare slots, then the idle gap
// after the last word of a frame.
`default_nettype none

module lmr_serial
    import lmr_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire lmr_cfg_t            cfg,
    input  wire logic                word_valid,
    input  wire lmr_word_t           word,
    output logic                     word_take,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [PULSE_W-1:0]       m_pulse_width,
    output logic [REPEAT_W-1:0]      m_repeat_slots,
    output logic                     m_last_of_run,
    output logic                     m_frame_end
);

    localparam logic [SLOT_CNT_W-1:0] LAST_BIT  = SLOT_CNT_W'(BITS_PER_LED - 1);
    localparam logic [SLOT_CNT_W-1:0] IDLE_SLOT = SLOT_CNT_W'(BITS_PER_LED);

    logic                    busy_reg;
    logic                    busy_next;
    logic [BITS_PER_LED-1:0] shift_reg;
    logic [BITS_PER_LED-1:0] shift_next;
    logic                    last_reg;
    logic                    last_next;
    logic [SLOT_CNT_W-1:0]   cnt_reg;
    logic [SLOT_CNT_W-1:0]   cnt_next;
    logic                    m_valid_reg;
    logic                    m_valid_next;
    logic [PULSE_W-1:0]      pulse_reg;
    logic [PULSE_W-1:0]      pulse_next;
    logic [REPEAT_W-1:0]     repeat_reg;
    logic [REPEAT_W-1:0]     repeat_next;
    logic                    lor_reg;
    logic                    lor_next;
    logic                    fe_reg;
    logic                    fe_next;
    logic                    out_adv;
    logic                    emit;
    logic                    final_slot;

    assign out_adv    = !m_valid_reg || m_ready;
    assign emit       = busy_reg && out_adv;
    assign final_slot = (cnt_reg == IDLE_SLOT) || ((cnt_reg == LAST_BIT) && !last_reg);
    assign word_take  = word_valid && (!busy_reg || (emit && final_slot));

    assign m_valid        = m_valid_reg;
    assign m_pulse_width  = pulse_reg;
    assign m_repeat_slots = repeat_reg;
    assign m_last_of_run  = lor_reg;
    assign m_frame_end    = fe_reg;

    always_comb begin
        busy_next    = busy_reg;
        shift_next   = shift_reg;
        last_next    = last_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg;
        pulse_next   = pulse_reg;
        repeat_next  = repeat_reg;
        lor_next     = lor_reg;
        fe_next      = fe_reg;

        if (out_adv) begin
            m_valid_next = busy_reg;
        end

        if (emit) begin
            if (cnt_reg == IDLE_SLOT) begin
                pulse_next  = '0;
                repeat_next = (cfg.idle_slot_count == '0) ? REPEAT_W'(1)
                                                          : cfg.idle_slot_count;
                lor_next    = 1'b1;
                fe_next     = 1'b1;
            end else begin
                pulse_next  = shift_reg[BITS_PER_LED-1] ? cfg.one_pulse_ticks
                                                        : cfg.zero_pulse_ticks;
                repeat_next = REPEAT_W'(1);
                lor_next    = (cnt_reg == LAST_BIT) && !last_reg;
                fe_next     = 1'b0;
            end
            shift_next = {shift_reg[BITS_PER_LED-2:0], 1'b0};
            cnt_next   = cnt_reg + 1'b1;
            if (final_slot) begin
                busy_next = 1'b0;
            end
        end

        if (word_take) begin
            busy_next  = 1'b1;
            shift_next = word.word;
            last_next  = word.last;
            cnt_next   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        shift_reg  <= shift_next;
        last_reg   <= last_next;
        cnt_reg    <= cnt_next;
        pulse_reg  <= pulse_next;
        repeat_reg <= repeat_next;
        lor_reg    <= lor_next;
        fe_reg     <= fe_next;
    end

endmodule

`default_nettype wire

[src/led_mode_render_pwm_encoder.sv]
// ----------------------------------------------------------------------------
// led_mode_render_pwm_encoder
// Renders one led per input word by mode and frame tick, then emits 24 PWM
// compare slots MSB first from green:red:blue, plus an idle gap after the last.
// The input word is registered in the render register, then loaded into the
// shift register, which emits one slot per cycle into the output register
// unless m_ready stalls it; the next led waits in the render register.
// Reset: aresetn synchronous active low clears tick, position and valids, and
// loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module led_mode_render_pwm_encoder
    import lmr_pkg::*;
#(
    parameter int MAX_LEDS = MAX_LEDS_DEFAULT
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic [COLOUR_W-1:0]    s_red,
    input  wire logic [COLOUR_W-1:0]    s_green,
    input  wire logic [COLOUR_W-1:0]    s_blue,
    input  wire logic [MODE_W-1:0]      s_led_mode,
    input  wire logic                   s_last_led,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic [PULSE_W-1:0]          m_pulse_width,
    output logic [REPEAT_W-1:0]         m_repeat_slots,
    output logic                        m_last_of_run,
    output logic                        m_frame_end
);

    lmr_cfg_t  cfg;
    lmr_word_t word;
    logic      word_valid;
    logic      word_take;

    lmr_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lmr_render #(
        .MAX_LEDS (MAX_LEDS)
    ) u_render (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_red      (s_red),
        .s_green    (s_green),
        .s_blue     (s_blue),
        .s_led_mode (s_led_mode),
        .s_last_led (s_last_led),
        .word_valid (word_valid),
        .word       (word),
        .word_take  (word_take)
    );

    lmr_serial u_serial (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg),
        .word_valid     (word_valid),
        .word           (word),
        .word_take      (word_take),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_pulse_width  (m_pulse_width),
        .m_repeat_slots (m_repeat_slots),
        .m_last_of_run  (m_last_of_run),
        .m_frame_end    (m_frame_end)
    );

endmodule

`default_nettype wire
